// File: design/sdis_pkg.sv
// Package for the SD card identification sequencer.
// Holds phase codes, command and response codes, constants and transaction types.
// No dependencies.
`default_nettype none

package sdis_pkg;

    localparam logic [3:0] PH_IDLE   = 4'd0;
    localparam logic [3:0] PH_CMD0   = 4'd1;
    localparam logic [3:0] PH_CMD8   = 4'd2;
    localparam logic [3:0] PH_CMD55  = 4'd3;
    localparam logic [3:0] PH_ACMD41 = 4'd4;
    localparam logic [3:0] PH_CMD2   = 4'd5;
    localparam logic [3:0] PH_CMD3   = 4'd6;
    localparam logic [3:0] PH_CMD9   = 4'd7;
    localparam logic [3:0] PH_CMD7   = 4'd8;
    localparam logic [3:0] PH_READY  = 4'd9;
    localparam logic [3:0] PH_NOCARD = 4'd10;
    localparam logic [3:0] PH_CMDERR = 4'd11;
    localparam logic [3:0] PH_NOTV2  = 4'd12;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_DONE  = 1'b1;

    localparam logic [1:0] RK_NONE   = 2'd0;
    localparam logic [1:0] RK_48     = 2'd1;
    localparam logic [1:0] RK_48BUSY = 2'd2;
    localparam logic [1:0] RK_136    = 2'd3;

    localparam logic [2:0] ST_RUNNING = 3'd0;
    localparam logic [2:0] ST_READY   = 3'd1;
    localparam logic [2:0] ST_NOCARD  = 3'd2;
    localparam logic [2:0] ST_CMDERR  = 3'd3;
    localparam logic [2:0] ST_NOTV2   = 3'd4;

    localparam logic [5:0] IDX_CMD0   = 6'd0;
    localparam logic [5:0] IDX_CMD2   = 6'd2;
    localparam logic [5:0] IDX_CMD3   = 6'd3;
    localparam logic [5:0] IDX_CMD7   = 6'd7;
    localparam logic [5:0] IDX_CMD8   = 6'd8;
    localparam logic [5:0] IDX_CMD9   = 6'd9;
    localparam logic [5:0] IDX_ACMD41 = 6'd41;
    localparam logic [5:0] IDX_CMD55  = 6'd55;

    localparam logic [31:0] IF_COND_ARG = (32'h1 << 8) | 32'h55;
    localparam logic [31:0] OP_COND_ARG = (32'h1 << 30) | (32'h3F << 15);
    localparam int          OCR_DONE_BIT = 31;

    typedef struct packed {
        logic        command;
        logic        card_present;
        logic        cmd_error;
        logic [31:0] response_word;
    } item_t;

    typedef struct packed {
        logic        issue;
        logic [5:0]  cmd_index;
        logic [1:0]  resp_kind;
        logic [31:0] cmd_argument;
        logic [2:0]  status;
        logic [15:0] card_address;
    } result_t;

endpackage

`default_nettype wire

// File: design/sdis_step.sv
// Next-phase and result logic of the SD card identification sequencer.
// Purely combinational; depends on sdis_pkg.
`default_nettype none

module sdis_step (
    input  wire sdis_pkg::item_t   item,
    input  wire logic [3:0]        phase,
    input  wire logic [15:0]       rel_address,
    output sdis_pkg::result_t      result,
    output logic [3:0]             phase_next,
    output logic [15:0]            rel_address_next
);

    logic [31:0] addr_arg;

    assign addr_arg = {rel_address, 16'h0000};

    always_comb
    begin
        phase_next          = phase;
        rel_address_next    = rel_address;
        result.issue        = 1'b0;
        result.cmd_index    = '0;
        result.resp_kind    = sdis_pkg::RK_NONE;
        result.cmd_argument = '0;

        if (item.command == sdis_pkg::CMD_START)
        begin
            if (item.card_present)
            begin
                result.issue     = 1'b1;
                result.cmd_index = sdis_pkg::IDX_CMD0;
                phase_next       = sdis_pkg::PH_CMD0;
            end
            else
            begin
                phase_next = sdis_pkg::PH_NOCARD;
            end
        end
        else if ((phase inside {[sdis_pkg::PH_CMD8:sdis_pkg::PH_CMD7]}) && item.cmd_error)
        begin
            phase_next = sdis_pkg::PH_CMDERR;
        end
        else
        begin
            case (phase)
                sdis_pkg::PH_CMD0:
                begin
                    result.issue        = 1'b1;
                    result.cmd_index    = sdis_pkg::IDX_CMD8;
                    result.resp_kind    = sdis_pkg::RK_48;
                    result.cmd_argument = sdis_pkg::IF_COND_ARG;
                    phase_next          = sdis_pkg::PH_CMD8;
                end
                sdis_pkg::PH_CMD8:
                begin
                    if (item.response_word != sdis_pkg::IF_COND_ARG)
                    begin
                        phase_next = sdis_pkg::PH_NOTV2;
                    end
                    else
                    begin
                        result.issue     = 1'b1;
                        result.cmd_index = sdis_pkg::IDX_CMD55;
                        result.resp_kind = sdis_pkg::RK_48BUSY;
                        phase_next       = sdis_pkg::PH_CMD55;
                    end
                end
                sdis_pkg::PH_CMD55:
                begin
                    result.issue        = 1'b1;
                    result.cmd_index    = sdis_pkg::IDX_ACMD41;
                    result.resp_kind    = sdis_pkg::RK_48BUSY;
                    result.cmd_argument = sdis_pkg::OP_COND_ARG;
                    phase_next          = sdis_pkg::PH_ACMD41;
                end
                sdis_pkg::PH_ACMD41:
                begin
                    result.issue = 1'b1;
                    if (item.response_word[sdis_pkg::OCR_DONE_BIT])
                    begin
                        result.cmd_index = sdis_pkg::IDX_CMD2;
                        result.resp_kind = sdis_pkg::RK_136;
                        phase_next       = sdis_pkg::PH_CMD2;
                    end
                    else
                    begin
                        result.cmd_index = sdis_pkg::IDX_CMD55;
                        result.resp_kind = sdis_pkg::RK_48BUSY;
                        phase_next       = sdis_pkg::PH_CMD55;
                    end
                end
                sdis_pkg::PH_CMD2:
                begin
                    result.issue     = 1'b1;
                    result.cmd_index = sdis_pkg::IDX_CMD3;
                    result.resp_kind = sdis_pkg::RK_48BUSY;
                    phase_next       = sdis_pkg::PH_CMD3;
                end
                sdis_pkg::PH_CMD3:
                begin
                    rel_address_next    = item.response_word[31:16];
                    result.issue        = 1'b1;
                    result.cmd_index    = sdis_pkg::IDX_CMD9;
                    result.resp_kind    = sdis_pkg::RK_136;
                    result.cmd_argument = {item.response_word[31:16], 16'h0000};
                    phase_next          = sdis_pkg::PH_CMD9;
                end
                sdis_pkg::PH_CMD9:
                begin
                    result.issue        = 1'b1;
                    result.cmd_index    = sdis_pkg::IDX_CMD7;
                    result.resp_kind    = sdis_pkg::RK_48BUSY;
                    result.cmd_argument = addr_arg;
                    phase_next          = sdis_pkg::PH_CMD7;
                end
                sdis_pkg::PH_CMD7:
                begin
                    phase_next = sdis_pkg::PH_READY;
                end
                default:
                begin
                    phase_next = phase;
                end
            endcase
        end

        case (phase_next)
            sdis_pkg::PH_READY:  result.status = sdis_pkg::ST_READY;
            sdis_pkg::PH_NOCARD: result.status = sdis_pkg::ST_NOCARD;
            sdis_pkg::PH_CMDERR: result.status = sdis_pkg::ST_CMDERR;
            sdis_pkg::PH_NOTV2:  result.status = sdis_pkg::ST_NOTV2;
            default:             result.status = sdis_pkg::ST_RUNNING;
        endcase

        result.card_address = rel_address_next;
    end

endmodule

`default_nettype wire

// File: design/sd_card_init_sequencer.sv
// Top level of the SD card identification sequencer: input register, phase and
// address state, result register. Depends on sdis_pkg and sdis_step.
// An accepted transaction goes to the input register, then to the result register.
// Throughput: one transaction per cycle unless out_ready stalls the result register.
// The input register accepts while empty, or while the result register moves on.
// Reset (rst_n low, asynchronous): phase idle, card address zero, both stages empty.
`default_nettype none

module sd_card_init_sequencer (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_ready,
    input  wire         command,
    input  wire         card_present,
    input  wire         cmd_error,
    input  wire  [31:0] response_word,
    output logic        out_valid,
    input  wire         out_ready,
    output logic        issue,
    output logic [5:0]  cmd_index,
    output logic [1:0]  resp_kind,
    output logic [31:0] cmd_argument,
    output logic [2:0]  status,
    output logic [15:0] card_address
);

    logic              in_valid_reg;
    sdis_pkg::item_t   in_item_reg;
    logic              out_valid_reg;
    sdis_pkg::result_t out_result_reg;
    logic [3:0]        phase_reg;
    logic [15:0]       rel_address_reg;

    logic [3:0]        phase_next;
    logic [15:0]       rel_address_next;
    sdis_pkg::result_t step_result;
    logic              out_take;
    logic              advance;

    assign out_take = !out_valid_reg || out_ready;
    assign advance  = in_valid_reg && out_take;
    assign in_ready = !in_valid_reg || out_take;

    sdis_step u_step (
        .item             (in_item_reg),
        .phase            (phase_reg),
        .rel_address      (rel_address_reg),
        .result           (step_result),
        .phase_next       (phase_next),
        .rel_address_next (rel_address_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            phase_reg       <= sdis_pkg::PH_IDLE;
            rel_address_reg <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (out_take)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (advance)
            begin
                phase_reg       <= phase_next;
                rel_address_reg <= rel_address_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_item_reg.command       <= command;
            in_item_reg.card_present  <= card_present;
            in_item_reg.cmd_error     <= cmd_error;
            in_item_reg.response_word <= response_word;
        end
        if (advance)
        begin
            out_result_reg <= step_result;
        end
    end

    assign out_valid    = out_valid_reg;
    assign issue        = out_result_reg.issue;
    assign cmd_index    = out_result_reg.cmd_index;
    assign resp_kind    = out_result_reg.resp_kind;
    assign cmd_argument = out_result_reg.cmd_argument;
    assign status       = out_result_reg.status;
    assign card_address = out_result_reg.card_address;

    a_issue_running: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && issue |-> status == sdis_pkg::ST_RUNNING)
        else $error("command issued with a final status");

    a_quiet_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !issue |-> cmd_index == '0 && resp_kind == sdis_pkg::RK_NONE
            && cmd_argument == '0)
        else $error("command fields set without issue");

    a_start_phase: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_item_reg.command == sdis_pkg::CMD_START && in_item_reg.card_present
        |=> phase_reg == sdis_pkg::PH_CMD0 && out_valid && issue
            && cmd_index == sdis_pkg::IDX_CMD0)
        else $error("start with card did not issue CMD0");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled with empty result register");

    a_address_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(rel_address_reg) && $stable(phase_reg))
        else $error("state changed without a transaction");

endmodule

`default_nettype wire

// File: bench/tb_top.sv
// Testbench for sd_card_init_sequencer: directed bring-up table, then random card sessions.
// Results are checked against typed table entries, else an in-bench sequence model.
// Depends on sdis_pkg and the sd_card_init_sequencer RTL.

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sdis_pkg::*;

    localparam int RANDOM_ITEMS = 1830;
    localparam int CALM_ITEMS   = 180;
    localparam int QUIET_LIMIT  = 1000;
    localparam int LONG_HOLD    = 60;

    typedef struct packed {
        item_t   stim;
        logic    typed;
        result_t want;
    } row_t;

    localparam result_t BLANK = '0;

    localparam int SCRIPT_LEN = 24;
    localparam row_t SCRIPT [SCRIPT_LEN] = '{
        {CMD_DONE,  1'b0, 1'b0, 32'h0000_0000,
            1'b1, 1'b0, 6'd0, RK_NONE, 32'h0, ST_RUNNING, 16'h0000},
        {CMD_START, 1'b0, 1'b0, 32'h0000_0000,
            1'b1, 1'b0, 6'd0, RK_NONE, 32'h0, ST_NOCARD, 16'h0000},
        {CMD_DONE,  1'b1, 1'b1, 32'hFFFF_FFFF,
            1'b1, 1'b0, 6'd0, RK_NONE, 32'h0, ST_NOCARD, 16'h0000},
        {CMD_START, 1'b1, 1'b0, 32'h0000_0000,
            1'b1, 1'b1, IDX_CMD0, RK_NONE, 32'h0, ST_RUNNING, 16'h0000},
        {CMD_DONE,  1'b0, 1'b1, 32'hFFFF_FFFF,
            1'b1, 1'b1, IDX_CMD8, RK_48, IF_COND_ARG, ST_RUNNING, 16'h0000},
        {CMD_DONE,  1'b0, 1'b0, 32'h8000_0155,
            1'b1, 1'b0, 6'd0, RK_NONE, 32'h0, ST_NOTV2, 16'h0000},
        {CMD_START, 1'b1, 1'b0, 32'h0000_0000, 1'b0, BLANK},
        {CMD_DONE,  1'b0, 1'b0, 32'h0000_0000, 1'b0, BLANK},
        {CMD_DONE,  1'b0, 1'b1, IF_COND_ARG,
            1'b1, 1'b0, 6'd0, RK_NONE, 32'h0, ST_CMDERR, 16'h0000},
        {CMD_START, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0, BLANK},
        {CMD_DONE,  1'b0, 1'b0, 32'h0000_0000, 1'b0, BLANK},
        {CMD_DONE,  1'b0, 1'b0, IF_COND_ARG,   1'b0, BLANK},
        {CMD_DONE,  1'b1, 1'b0, 32'hFFFF_FFFF, 1'b0, BLANK},
        {CMD_DONE,  1'b0, 1'b0, 32'h7FFF_FFFF, 1'b0, BLANK},
        {CMD_DONE,  1'b0, 1'b0, 32'h0000_0000, 1'b0, BLANK},
        {CMD_DONE,  1'b0, 1'b0, 32'h8000_0000, 1'b0, BLANK},
        {CMD_DONE,  1'b0, 1'b0, 32'h0000_0000, 1'b0, BLANK},
        {CMD_DONE,  1'b0, 1'b0, 32'hFFFF_0000, 1'b0, BLANK},
        {CMD_DONE,  1'b0, 1'b0, 32'h0000_0000, 1'b0, BLANK},
        {CMD_DONE,  1'b0, 1'b0, 32'h0000_0000,
            1'b1, 1'b0, 6'd0, RK_NONE, 32'h0, ST_READY, 16'hFFFF},
        {CMD_DONE,  1'b1, 1'b1, 32'h0000_FFFF, 1'b0, BLANK},
        {CMD_START, 1'b1, 1'b0, 32'h0000_0000, 1'b0, BLANK},
        {CMD_DONE,  1'b0, 1'b0, 32'h0000_0000, 1'b0, BLANK},
        {CMD_START, 1'b0, 1'b0, 32'h0000_0000,
            1'b1, 1'b0, 6'd0, RK_NONE, 32'h0, ST_NOCARD, 16'hFFFF}
    };

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        in_valid      = 1'b0;
    logic        in_ready;
    logic        command       = CMD_DONE;
    logic        card_present  = 1'b0;
    logic        cmd_error     = 1'b0;
    logic [31:0] response_word = 32'h0;
    logic        out_valid;
    logic        out_ready     = 1'b0;
    logic        issue;
    logic [5:0]  cmd_index;
    logic [1:0]  resp_kind;
    logic [31:0] cmd_argument;
    logic [2:0]  status;
    logic [15:0] card_address;

    logic [3:0]  card_phase = PH_IDLE;
    logic [15:0] card_rca   = 16'h0000;
    result_t     steps_due [$];
    result_t     seen;
    int          mismatch_count = 0;
    int          quiet_cycles   = 0;
    bit          calm           = 1'b0;
    bit          hold_long      = 1'b0;

    sd_card_init_sequencer i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .card_present  (card_present),
        .cmd_error     (cmd_error),
        .response_word (response_word),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .issue         (issue),
        .cmd_index     (cmd_index),
        .resp_kind     (resp_kind),
        .cmd_argument  (cmd_argument),
        .status        (status),
        .card_address  (card_address)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic result_t card_cmd(logic [5:0] idx, logic [1:0] kind, logic [31:0] arg);
        result_t r;
        r              = '0;
        r.issue        = 1'b1;
        r.cmd_index    = idx;
        r.resp_kind    = kind;
        r.cmd_argument = arg;
        return r;
    endfunction

    function automatic result_t step_card(item_t it);
        result_t     r;
        logic [31:0] addr_arg;
        r        = '0;
        addr_arg = {card_rca, 16'h0000};
        if (it.command == CMD_START)
        begin
            if (it.card_present)
            begin
                r          = card_cmd(IDX_CMD0, RK_NONE, 32'h0);
                card_phase = PH_CMD0;
            end
            else
                card_phase = PH_NOCARD;
        end
        else if (card_phase >= PH_CMD8 && card_phase <= PH_CMD7 && it.cmd_error)
            card_phase = PH_CMDERR;
        else
        begin
            case (card_phase)
                PH_CMD0:
                begin
                    r          = card_cmd(IDX_CMD8, RK_48, IF_COND_ARG);
                    card_phase = PH_CMD8;
                end
                PH_CMD8:
                begin
                    if (it.response_word != IF_COND_ARG)
                        card_phase = PH_NOTV2;
                    else
                    begin
                        r          = card_cmd(IDX_CMD55, RK_48BUSY, 32'h0);
                        card_phase = PH_CMD55;
                    end
                end
                PH_CMD55:
                begin
                    r          = card_cmd(IDX_ACMD41, RK_48BUSY, OP_COND_ARG);
                    card_phase = PH_ACMD41;
                end
                PH_ACMD41:
                begin
                    if (it.response_word[OCR_DONE_BIT])
                    begin
                        r          = card_cmd(IDX_CMD2, RK_136, 32'h0);
                        card_phase = PH_CMD2;
                    end
                    else
                    begin
                        r          = card_cmd(IDX_CMD55, RK_48BUSY, 32'h0);
                        card_phase = PH_CMD55;
                    end
                end
                PH_CMD2:
                begin
                    r          = card_cmd(IDX_CMD3, RK_48BUSY, 32'h0);
                    card_phase = PH_CMD3;
                end
                PH_CMD3:
                begin
                    card_rca   = it.response_word[31:16];
                    r          = card_cmd(IDX_CMD9, RK_136, {it.response_word[31:16], 16'h0000});
                    card_phase = PH_CMD9;
                end
                PH_CMD9:
                begin
                    r          = card_cmd(IDX_CMD7, RK_48BUSY, addr_arg);
                    card_phase = PH_CMD7;
                end
                PH_CMD7:
                    card_phase = PH_READY;
                default:
                    ;
            endcase
        end
        case (card_phase)
            PH_READY:  r.status = ST_READY;
            PH_NOCARD: r.status = ST_NOCARD;
            PH_CMDERR: r.status = ST_CMDERR;
            PH_NOTV2:  r.status = ST_NOTV2;
            default:   r.status = ST_RUNNING;
        endcase
        r.card_address = card_rca;
        return r;
    endfunction

    // Mostly well-formed sessions: proper echoes, random poll counts, rare errors and restarts.
    function automatic item_t draw_completion();
        item_t       it;
        int unsigned roll;
        it.command       = CMD_DONE;
        it.card_present  = 1'($urandom_range(0, 1));
        it.cmd_error     = 1'($urandom_range(0, 1));
        it.response_word = $urandom;
        roll             = $urandom_range(0, 99);
        if (card_phase >= PH_CMD0 && card_phase <= PH_CMD7)
        begin
            if (roll < 2)
                it.command = CMD_START;
            else
            begin
                it.cmd_error = (roll < 5);
                case (card_phase)
                    PH_CMD8:
                    begin
                        if (roll < 92)
                            it.response_word = IF_COND_ARG;
                        else if (roll < 96)
                            it.response_word = IF_COND_ARG ^ (32'h1 << $urandom_range(0, 31));
                    end
                    PH_ACMD41:
                        it.response_word[OCR_DONE_BIT] = (roll < 40);
                    default:
                        ;
                endcase
            end
        end
        else if (roll < 85)
        begin
            it.command      = CMD_START;
            it.card_present = 1'b1;
        end
        else if (roll < 92)
        begin
            it.command      = CMD_START;
            it.card_present = 1'b0;
        end
        return it;
    endfunction

    task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatch_count++;
        $display("tb_top: mismatch on %s at %0t: got %h, want %h", what, $realtime, got, want);
    endtask

    task automatic offer(item_t it, bit typed, result_t want);
        result_t guess;
        in_valid      <= 1'b1;
        command       <= it.command;
        card_present  <= it.card_present;
        cmd_error     <= it.cmd_error;
        response_word <= it.response_word;
        do
            @(posedge clk);
        while (!in_ready);
        guess = step_card(it);
        steps_due.push_back(typed ? want : guess);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        for (int i = 0; i < SCRIPT_LEN; i++)
            offer(SCRIPT[i].stim, SCRIPT[i].typed, SCRIPT[i].want);
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 2)
            begin
                in_valid <= 1'b0;
                wait (steps_due.size() == 0);
                @(posedge clk);
            end
            if (n == 400 || n == 1200)
                hold_long = 1'b1;
            if (n == RANDOM_ITEMS - CALM_ITEMS)
                calm = 1'b1;
            offer(draw_completion(), 1'b0, BLANK);
        end
        in_valid <= 1'b0;
        wait (steps_due.size() == 0);
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            if (hold_long)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_long = 1'b0;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                seen = {issue, cmd_index, resp_kind, cmd_argument, status, card_address};
                if (steps_due.size() == 0)
                    flag_mismatch("unexpected result", seen.cmd_argument, 32'h0);
                else
                begin
                    result_t want;
                    want = steps_due.pop_front();
                    if (seen.issue !== want.issue)
                        flag_mismatch("issue", 32'(seen.issue), 32'(want.issue));
                    if (seen.cmd_index !== want.cmd_index)
                        flag_mismatch("cmd_index", 32'(seen.cmd_index), 32'(want.cmd_index));
                    if (seen.resp_kind !== want.resp_kind)
                        flag_mismatch("resp_kind", 32'(seen.resp_kind), 32'(want.resp_kind));
                    if (seen.cmd_argument !== want.cmd_argument)
                        flag_mismatch("cmd_argument", seen.cmd_argument, want.cmd_argument);
                    if (seen.status !== want.status)
                        flag_mismatch("status", 32'(seen.status), 32'(want.status));
                    if (seen.card_address !== want.card_address)
                        flag_mismatch("card_address", 32'(seen.card_address),
                            32'(want.card_address));
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("tb_top: errors");
                $finish;
            end
        end
    end

endmodule

// File: filelist.f
design/sdis_pkg.sv
design/sdis_step.sv
design/sd_card_init_sequencer.sv
bench/tb_top.sv
